// File: rtl/core/dqip_pkg.sv
// ----------------------------------------------------------------------------
// dqip_pkg
// Character codes, parser state and result types for the dotted-quad parser.
// ----------------------------------------------------------------------------
package dqip_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [9:0] SEG_MAX  = 10'd255;
    localparam logic [1:0] LAST_SEG = 2'd3;
    localparam logic [1:0] MAX_DIGITS = 2'd3;

    typedef struct packed {
        logic [1:0]  segment_index;
        logic [1:0]  digit_count;
        logic [9:0]  segment_value;
        logic [23:0] partial_address;
        logic        skip_to_end;
    } parse_state_t;

    typedef struct packed {
        logic [31:0] address;
        logic        failed;
    } parse_result_t;

endpackage

// File: rtl/core/dotted_quad_ip_parser_core.sv
// ----------------------------------------------------------------------------
// dotted_quad_ip_parser_core
// Streaming IPv4 dotted-decimal parser, one character per request.
// ----------------------------------------------------------------------------
// Output: a result appears on the m_ channel in the cycle after the character
// that ends the string or reveals an error is accepted.
// Throughput: one character per cycle while m_ready is high; a waiting result
// holds s_ready low until drained.
// Reset: synchronous active-low aresetn clears the parse state and m_valid.
module dotted_quad_ip_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_address,
    output logic        m_failed
);
    import dqip_pkg::*;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_result;
    logic          step_emit;
    logic          accept;
    logic          m_valid_reg;
    logic [31:0]   m_address_reg;
    logic          m_failed_reg;

    dqip_step u_step (
        .cur_state  (state_reg),
        .char_code  (s_char_code),
        .next_state (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // advance when the output register is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept && step_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step_emit) begin
            m_address_reg <= step_result.address;
            m_failed_reg  <= step_result.failed;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_address = m_address_reg;
    assign m_failed  = m_failed_reg;

endmodule

// File: rtl/core/dqip_step.sv
// ----------------------------------------------------------------------------
// dqip_step
// Next-state and result logic for one character of the address string.
// ----------------------------------------------------------------------------
module dqip_step (
    input  dqip_pkg::parse_state_t  cur_state,
    input  logic [7:0]              char_code,
    output dqip_pkg::parse_state_t  next_state,
    output logic                    emit,
    output dqip_pkg::parse_result_t result
);
    import dqip_pkg::*;

    logic        seg_ok;
    logic        last_seg;
    logic [31:0] full_address;
    logic [3:0]  digit;
    logic [9:0]  value_x10;

    assign seg_ok       = (cur_state.digit_count != 2'd0) &&
                          (cur_state.segment_value <= SEG_MAX);
    assign last_seg     = (cur_state.segment_index == LAST_SEG);
    assign full_address = {cur_state.partial_address, cur_state.segment_value[7:0]};
    assign digit        = char_code[3:0] - CH_ZERO[3:0];
    // times ten as shift-add; at most two digits precede, so no overflow
    assign value_x10    = {cur_state.segment_value[6:0], 3'b000} +
                          {cur_state.segment_value[8:0], 1'b0};

    always_comb begin
        next_state     = cur_state;
        emit           = 1'b0;
        result.address = 32'd0;
        result.failed  = 1'b1;
        if (cur_state.skip_to_end) begin
            // drop everything up to the terminating NUL
            if (char_code == CH_NUL) begin
                next_state = '0;
            end
        end else begin
            case (char_code)
                CH_NUL: begin
                    emit       = 1'b1;
                    next_state = '0;
                    if (seg_ok && last_seg) begin
                        result.address = full_address;
                        result.failed  = 1'b0;
                    end
                end
                CH_DOT: begin
                    if (!seg_ok || last_seg) begin
                        emit                   = 1'b1;
                        next_state             = '0;
                        next_state.skip_to_end = 1'b1;
                    end else begin
                        next_state.partial_address = {cur_state.partial_address[15:0],
                                                      cur_state.segment_value[7:0]};
                        next_state.segment_index   = cur_state.segment_index + 2'd1;
                        next_state.digit_count     = 2'd0;
                        next_state.segment_value   = 10'd0;
                    end
                end
                CH_COLON: begin
                    emit                   = 1'b1;
                    next_state             = '0;
                    next_state.skip_to_end = 1'b1;
                    if (seg_ok && last_seg) begin
                        result.address = full_address;
                        result.failed  = 1'b0;
                    end
                end
                default: begin
                    if ((char_code inside {[CH_ZERO:CH_NINE]}) &&
                        (cur_state.digit_count != MAX_DIGITS)) begin
                        next_state.segment_value = value_x10 + {6'd0, digit};
                        next_state.digit_count   = cur_state.digit_count + 2'd1;
                    end else begin
                        // fourth digit or a stray character
                        emit                   = 1'b1;
                        next_state             = '0;
                        next_state.skip_to_end = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule
